// ===== hdl/srawm_pkg.sv =====
// Shared types and constants for the sample ring average and window minimum unit.
package srawm_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int ANSWER_W  = 12;

    localparam logic [SAMPLE_W-1:0] EMPTY_MIN = 12'd4095;

    // Item kinds
    localparam logic [1:0] KIND_STORE  = 2'd0;
    localparam logic [1:0] KIND_AVG    = 2'd1;
    localparam logic [1:0] KIND_MIN    = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Result kinds
    localparam logic ANS_AVG = 1'b0;
    localparam logic ANS_MIN = 1'b1;

    typedef struct packed {
        logic [1:0]          kind;
        logic [SAMPLE_W-1:0] sample;
        logic [7:0]          window_start;
        logic [8:0]          window_length;
    } t_in;

    typedef struct packed {
        logic [ANSWER_W-1:0] answer;
        logic                answer_kind;
    } t_out;

    // Store port strobes
    typedef struct packed {
        logic wr;
        logic rd;
    } t_mem_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DIV
    } t_state;

endpackage

// ===== hdl/srawm_store.sv =====
// Sample store: single-port-write, registered-read memory with fill-count zero masking.
module srawm_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srawm_pkg::t_mem_ctl           i_ctl,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [srawm_pkg::SAMPLE_W-1:0] i_wdata,
    input  logic [AW-1:0]                 i_raddr,
    output logic [srawm_pkg::SAMPLE_W-1:0] o_rdata
);
    import srawm_pkg::*;

    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;
    logic                r_hit;
    logic [FILL_W-1:0]   r_fill;

    // Write the entry at the pointer
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // Count written entries; writes fill the store in address order after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_hit  <= 1'b0;
        end else begin
            if (i_ctl.wr && (r_fill != FILL_W'(DEPTH))) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            if (i_ctl.rd) begin
                r_hit <= (FILL_W'(i_raddr) < r_fill);
            end
        end
    end

    // Entries not yet written read as zero
    assign o_rdata = r_hit ? r_rdata : '0;

endmodule

// ===== hdl/srawm_div.sv =====
// Division of the average sum by a constant through reciprocal multiplication.
module srawm_div #(
    parameter int DIVISOR = 16,
    parameter int SUM_W   = 17
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [SUM_W-1:0]               i_dividend,
    output logic                           o_done,
    output logic [srawm_pkg::ANSWER_W-1:0] o_quot
);
    import srawm_pkg::*;

    localparam int DIV_W  = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
    localparam int SHIFT  = SUM_W + DIV_W;
    localparam int RCP_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + RCP_W;
    localparam longint unsigned RCP_FULL =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);

    logic [PROD_W-1:0]   prod;
    logic [ANSWER_W-1:0] r_quot;
    logic                r_done;

    // Multiply by the rounded-up reciprocal; the shift drops the fraction exactly
    assign prod = PROD_W'(i_dividend) * PROD_W'(RCP);

    // Flag the quotient in the cycle after start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    // Hold the quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= prod[SHIFT +: ANSWER_W];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hdl/sample_ring_avg_and_window_min_unit.sv =====
// Top level: circular sample history with moving average and window minimum queries.
//
// Usage: an item is transferred at a rising edge with start high and busy low.
// A store item writes its sample at the write pointer, advances the pointer
// and gives no result; busy stays low, so stores may follow every cycle.
// An average query walks the AVG_SAMPLES entries before the pointer through
// the store's read port, one read per cycle, then divides the sum by
// AVG_SAMPLES with a reciprocal multiplication. A window query walks
// window_length entries (clamped to BUFFER_DEPTH) forward from window_start,
// wrapping; an empty window answers 4095 in the cycle after transfer. The
// walk through the single read port sets the query time. Busy is high while
// a query runs. Each result is shown for one cycle with o_strobe high and
// must be taken then; the receiver cannot hold it off. The next item may be
// transferred in the same cycle as a result is shown.
// Reset clears the write pointer and the fill count; entries not yet
// written since reset read as zero, so no clearing pass is needed.
module sample_ring_avg_and_window_min_unit #(
    parameter int BUFFER_DEPTH = 256,
    parameter int AVG_SAMPLES  = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  srawm_pkg::t_in  i_item,
    output logic            o_strobe,
    output srawm_pkg::t_out o_result
);
    import srawm_pkg::*;

    localparam int AW      = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_MAX = (BUFFER_DEPTH > AVG_SAMPLES) ? BUFFER_DEPTH : AVG_SAMPLES;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int SUM_W   = SAMPLE_W + $clog2(AVG_SAMPLES + 1);
    localparam int RED_W   = 13;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_wptr, n_wptr;
    logic [AW-1:0]       r_addr, n_addr;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_rvalid, n_rvalid;
    logic                r_is_min, n_is_min;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [SAMPLE_W-1:0] r_min, n_min;
    logic                r_strobe, n_strobe;
    t_out                r_result, n_result;

    t_mem_ctl            mem_ctl;
    logic [SAMPLE_W-1:0] rdata;
    logic                accept;
    logic                walk_done;
    logic                div_start;
    logic                div_done;
    logic [ANSWER_W-1:0] div_quot;
    logic [AW-1:0]       start_addr;
    logic [CNT_W-1:0]    len_eff;
    logic [AW-1:0]       wptr_prev;

    assign accept    = start && (r_state == ST_IDLE);
    assign busy      = (r_state != ST_IDLE);
    assign walk_done = (r_cnt == '0) && !r_rvalid;
    assign div_start = (r_state == ST_WALK) && walk_done && !r_is_min;
    assign wptr_prev = (r_wptr == '0) ? AW'(BUFFER_DEPTH - 1) : r_wptr - AW'(1);

    // Reduce the window start modulo the depth by binary subtraction
    always_comb begin
        logic [RED_W-1:0] v;
        v = RED_W'(i_item.window_start);
        for (int k = 7; k >= 0; k--) begin
            if (int'(v) >= (BUFFER_DEPTH << k)) begin
                v = v - RED_W'(BUFFER_DEPTH << k);
            end
        end
        start_addr = AW'(v);
    end

    // Clamp the window length to the depth
    assign len_eff = (int'(i_item.window_length) > BUFFER_DEPTH) ?
                     CNT_W'(BUFFER_DEPTH) : CNT_W'(i_item.window_length);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_item.kind == KIND_AVG)) begin
                    n_state = ST_WALK;
                end else if (accept && (i_item.kind == KIND_MIN) && (len_eff != '0)) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (walk_done) begin
                    n_state = r_is_min ? ST_IDLE : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath controls and results
    always_comb begin
        mem_ctl.wr = accept && (i_item.kind == KIND_STORE);
        mem_ctl.rd = (r_state == ST_WALK) && (r_cnt != '0);
        n_wptr     = r_wptr;
        n_addr     = r_addr;
        n_cnt      = r_cnt;
        n_rvalid   = mem_ctl.rd;
        n_is_min   = r_is_min;
        n_sum      = r_sum;
        n_min      = r_min;
        n_strobe   = 1'b0;
        n_result   = r_result;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_item.kind)
                        KIND_STORE: begin
                            n_wptr = (r_wptr == AW'(BUFFER_DEPTH - 1)) ? '0 : r_wptr + AW'(1);
                        end
                        KIND_AVG: begin
                            n_addr   = wptr_prev;
                            n_cnt    = CNT_W'(AVG_SAMPLES);
                            n_is_min = 1'b0;
                            n_sum    = '0;
                        end
                        KIND_MIN: begin
                            n_addr   = start_addr;
                            n_cnt    = len_eff;
                            n_is_min = 1'b1;
                            n_min    = EMPTY_MIN;
                            if (len_eff == '0) begin
                                n_strobe             = 1'b1;
                                n_result.answer      = EMPTY_MIN;
                                n_result.answer_kind = ANS_MIN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                // Step the read address: backwards for the average, forwards for the window
                if (mem_ctl.rd) begin
                    n_cnt = r_cnt - CNT_W'(1);
                    if (r_is_min) begin
                        n_addr = (r_addr == AW'(BUFFER_DEPTH - 1)) ? '0 : r_addr + AW'(1);
                    end else begin
                        n_addr = (r_addr == '0) ? AW'(BUFFER_DEPTH - 1) : r_addr - AW'(1);
                    end
                end
                // Fold in the entry read last cycle
                if (r_rvalid) begin
                    n_sum = r_sum + SUM_W'(rdata);
                    if (rdata < r_min) begin
                        n_min = rdata;
                    end
                end
                if (walk_done && r_is_min) begin
                    n_strobe             = 1'b1;
                    n_result.answer      = r_min;
                    n_result.answer_kind = ANS_MIN;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_strobe             = 1'b1;
                    n_result.answer      = div_quot;
                    n_result.answer_kind = ANS_AVG;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wptr   <= '0;
            r_cnt    <= '0;
            r_rvalid <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wptr   <= n_wptr;
            r_cnt    <= n_cnt;
            r_rvalid <= n_rvalid;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_is_min <= n_is_min;
        r_sum    <= n_sum;
        r_min    <= n_min;
        r_result <= n_result;
    end

    srawm_store #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mem_ctl),
        .i_waddr (r_wptr),
        .i_wdata (i_item.sample),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    srawm_div #(
        .DIVISOR (AVG_SAMPLES),
        .SUM_W   (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
